// File: design/ddoi_pkg.sv
package ddoi_pkg;

  localparam int OP_W = 34;
  localparam int PROD_W = 2 * OP_W;

  localparam logic signed [OP_W-1:0] PI_Q28 = 34'sd843314857;
  localparam logic signed [OP_W-1:0] TWO_PI_Q28 = 34'sd1686629713;
  localparam logic signed [OP_W-1:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [OP_W-1:0] CORDIC_K_Q30 = 34'sd652032874;

  localparam logic [1:0] REG_MM_PER_COUNT = 2'd0;
  localparam logic [1:0] REG_RAD_PER_COUNT = 2'd1;
  localparam logic [1:0] REG_SAMPLES_PER_SECOND = 2'd2;

  localparam logic [31:0] MM_PER_COUNT_RST = 32'd915043;
  localparam logic [31:0] RAD_PER_COUNT_RST = 32'd223690000;
  localparam logic [15:0] SAMPLES_PER_SECOND_RST = 16'd200;

  function automatic logic signed [OP_W-1:0] atan_q28(input int i);
    logic signed [OP_W-1:0] r;
    case (i)
      0: r = 34'sd210828714;
      1: r = 34'sd124459457;
      2: r = 34'sd65760959;
      3: r = 34'sd33381290;
      4: r = 34'sd16755422;
      5: r = 34'sd8385879;
      6: r = 34'sd4193963;
      7: r = 34'sd2097109;
      8: r = 34'sd1048571;
      9: r = 34'sd524287;
      10: r = 34'sd262144;
      default: begin
        if (i <= 28) r = 34'sd1 <<< (28 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sd140737488355327) r = {1'b0, {47{1'b1}}};
    else if (v < -50'sd140737488355328) r = {1'b1, {47{1'b0}}};
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] wrap_angle(input logic signed [OP_W:0] a);
    logic signed [OP_W:0] v;
    v = a;
    if (v > 35'(PI_Q28)) v = v - 35'(TWO_PI_Q28);
    if (v > 35'(PI_Q28)) v = v - 35'(TWO_PI_Q28);
    if (v <= -35'(PI_Q28)) v = v + 35'(TWO_PI_Q28);
    if (v <= -35'(PI_Q28)) v = v + 35'(TWO_PI_Q28);
    return v[31:0];
  endfunction

endpackage

// File: design/ddoi_mult.sv
module ddoi_mult (
  input  logic clk,
  input  logic en,
  input  logic signed [ddoi_pkg::OP_W-1:0] a,
  input  logic signed [ddoi_pkg::OP_W-1:0] b,
  output logic signed [ddoi_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) p <= a * b;
  end

endmodule

// File: design/ddoi_cordic.sv
module ddoi_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [31:0] angle,
  output logic done,
  output logic signed [ddoi_pkg::OP_W-1:0] cos_q30,
  output logic signed [ddoi_pkg::OP_W-1:0] sin_q30
);

  localparam int IW = $clog2(CORDIC_STEPS);

  logic signed [ddoi_pkg::OP_W-1:0] x;
  logic signed [ddoi_pkg::OP_W-1:0] y;
  logic signed [ddoi_pkg::OP_W-1:0] z;
  logic signed [ddoi_pkg::OP_W-1:0] ang;
  logic [IW-1:0] cnt;
  logic busy;
  logic neg;

  assign ang = ddoi_pkg::OP_W'(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == IW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= ddoi_pkg::CORDIC_K_Q30;
      y <= '0;
      if (ang > ddoi_pkg::HALF_PI_Q28) begin
        z <= ang - ddoi_pkg::PI_Q28;
        neg <= 1'b1;
      end else if (ang < -ddoi_pkg::HALF_PI_Q28) begin
        z <= ang + ddoi_pkg::PI_Q28;
        neg <= 1'b1;
      end else begin
        z <= ang;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        z <= z - ddoi_pkg::atan_q28(int'(cnt));
      end else begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        z <= z + ddoi_pkg::atan_q28(int'(cnt));
      end
    end
  end

  assign cos_q30 = neg ? -x : x;
  assign sin_q30 = neg ? -y : y;

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("cordic restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("cordic done without run");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= IW'(CORDIC_STEPS - 1)) else $error("cordic step overrun");
`endif

endmodule

// File: design/diff_drive_odometry_integrator.sv
// differential drive odometry integrator
// input channel: in_valid / in_stall carry right_count and left_count, the
// signed encoder increments of one sample period; an item is taken at a
// clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall carry the updated pose (pos_x, pos_y,
// heading) and the velocities speed_linear and speed_angular
// config port: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// mm_per_count, 1 rad_per_count, 2 samples_per_second, others are ignored;
// cfg_ready is always high, write only while the block is idle
// one item at a time: in_stall stays high from acceptance until the result
// is loaded into the output register
// from acceptance to out_valid an item steps through the states MD, MT, MID,
// CS, CW, MX, MY, ML, MA and FIN: the iterative cordic runs in CW, one
// rotation per cycle, and six passes go through the single shared registered
// multiplier; a new item is taken only after the last one leaves FIN
// a finished result waits in the output register while out_stall is high;
// a following item can be accepted meanwhile and waits in its last step
// rst (synchronous) clears the pose accumulators to zero and loads the register defaults
module diff_drive_odometry_integrator #(
  parameter int CORDIC_STEPS = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COUNT_BITS-1:0] right_count,
  input  logic signed [COUNT_BITS-1:0] left_count,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [30:0] heading,
  output logic signed [31:0] speed_linear,
  output logic signed [31:0] speed_angular,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int W = ddoi_pkg::OP_W;
  localparam int PW = ddoi_pkg::PROD_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MD = 4'd1;
  localparam logic [3:0] S_MT = 4'd2;
  localparam logic [3:0] S_MID = 4'd3;
  localparam logic [3:0] S_CS = 4'd4;
  localparam logic [3:0] S_CW = 4'd5;
  localparam logic [3:0] S_MX = 4'd6;
  localparam logic [3:0] S_MY = 4'd7;
  localparam logic [3:0] S_ML = 4'd8;
  localparam logic [3:0] S_MA = 4'd9;
  localparam logic [3:0] S_FIN = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [31:0] mm_per_count;
  logic [31:0] rad_per_count;
  logic [15:0] samples_per_second;
  logic signed [COUNT_BITS-1:0] r_cnt;
  logic signed [COUNT_BITS-1:0] l_cnt;
  logic signed [31:0] distance;
  logic signed [31:0] turn;
  logic signed [31:0] sl;
  logic signed [47:0] acc_x;
  logic signed [47:0] acc_y;
  logic signed [31:0] acc_heading;
  logic signed [31:0] mid_heading;
  logic signed [W-1:0] mul_a;
  logic signed [W-1:0] mul_b;
  logic mul_en;
  logic signed [PW-1:0] prod;
  logic signed [COUNT_BITS:0] sum;
  logic signed [COUNT_BITS:0] diff;
  logic signed [31:0] turn_now;
  logic signed [31:0] acc_heading_next;
  logic cor_done;
  logic signed [W-1:0] cos_q30;
  logic signed [W-1:0] sin_q30;
  logic load_out;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  assign sum = {r_cnt[COUNT_BITS-1], r_cnt} + {l_cnt[COUNT_BITS-1], l_cnt};
  assign diff = {r_cnt[COUNT_BITS-1], r_cnt} - {l_cnt[COUNT_BITS-1], l_cnt};
  assign turn_now = ddoi_pkg::sat32(prod >>> 20);
  assign acc_heading_next = ddoi_pkg::wrap_angle((W+1)'(acc_heading) + (W+1)'(turn));
  assign load_out = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    mul_en = 1'b1;
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MD: begin
        mul_a = W'(sum);
        mul_b = {2'b00, mm_per_count};
      end
      S_MT: begin
        mul_a = W'(diff);
        mul_b = {2'b00, rad_per_count};
      end
      S_MX: begin
        mul_a = W'(distance);
        mul_b = cos_q30;
      end
      S_MY: begin
        mul_a = W'(distance);
        mul_b = sin_q30;
      end
      S_ML: begin
        mul_a = W'(distance);
        mul_b = {18'd0, samples_per_second};
      end
      S_MA: begin
        mul_a = W'(turn);
        mul_b = {18'd0, samples_per_second};
      end
      default: mul_en = 1'b0;
    endcase
  end

  ddoi_mult u_mult (
    .clk(clk),
    .en(mul_en),
    .a(mul_a),
    .b(mul_b),
    .p(prod)
  );

  ddoi_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .start(state == S_CS),
    .angle(mid_heading),
    .done(cor_done),
    .cos_q30(cos_q30),
    .sin_q30(sin_q30)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_MD;
      S_MD: state_next = S_MT;
      S_MT: state_next = S_MID;
      S_MID: state_next = S_CS;
      S_CS: state_next = S_CW;
      S_CW: if (cor_done) state_next = S_MX;
      S_MX: state_next = S_MY;
      S_MY: state_next = S_ML;
      S_ML: state_next = S_MA;
      S_MA: state_next = S_FIN;
      S_FIN: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mm_per_count <= ddoi_pkg::MM_PER_COUNT_RST;
      rad_per_count <= ddoi_pkg::RAD_PER_COUNT_RST;
      samples_per_second <= ddoi_pkg::SAMPLES_PER_SECOND_RST;
      acc_x <= '0;
      acc_y <= '0;
      acc_heading <= '0;
      mid_heading <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          ddoi_pkg::REG_MM_PER_COUNT: mm_per_count <= cfg_data;
          ddoi_pkg::REG_RAD_PER_COUNT: rad_per_count <= cfg_data;
          ddoi_pkg::REG_SAMPLES_PER_SECOND: samples_per_second <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state == S_MID)
        mid_heading <= ddoi_pkg::wrap_angle((W+1)'(acc_heading) + (W+1)'(turn_now >>> 1));
      if (state == S_MY) acc_x <= ddoi_pkg::sat48(50'(acc_x) + 50'(prod >>> 30));
      if (state == S_ML) acc_y <= ddoi_pkg::sat48(50'(acc_y) + 50'(prod >>> 30));
      if (load_out) begin
        acc_heading <= acc_heading_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      r_cnt <= right_count;
      l_cnt <= left_count;
    end
    if (state == S_MT) distance <= ddoi_pkg::sat32(prod >>> 17);
    if (state == S_MID) turn <= turn_now;
    if (state == S_MA) sl <= ddoi_pkg::sat32(prod);
    if (load_out) begin
      pos_x <= acc_x;
      pos_y <= acc_y;
      heading <= acc_heading_next[30:0];
      speed_linear <= sl;
      speed_angular <= ddoi_pkg::sat32(prod >>> 12);
    end
  end

`ifndef ASSERT_OFF
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    (W'(acc_heading) <= ddoi_pkg::PI_Q28) && (W'(acc_heading) > -ddoi_pkg::PI_Q28))
    else $error("heading out of range");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("item accepted but not busy");
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN) else $error("result without finish");
`endif

endmodule
